// ----- rtl/bole_pkg.sv -----
`default_nettype none

package bole_pkg;

    // Field widths of the item payloads.
    localparam int ACTION_W     = 3;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 3;
    localparam int LEN_W        = 5;
    localparam int CAPACITY_DEF = 16;

    // Requested action of an input item.
    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD  = 3'd0,
        ACT_INS_TAIL  = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_VALUE = 3'd3,
        ACT_DEL_POS   = 3'd4,
        ACT_SEARCH    = 3'd5
    } action_t;

    // Status code of a result item.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_BOUNDS   = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic cmp;        // register the compare of the cell against the value
        logic ins;        // open a gap at the index and load the value
        logic del_at;     // close the gap at the index
        logic del_match;  // close the gap at the first matching cell
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/bole_cell.sv -----
`default_nettype none

module bole_cell
    import bole_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic               aclk,
    input  wire cell_cmd_t          cmd,
    input  wire logic [CW-1:0]      at_idx,
    input  wire logic [CW-1:0]      len,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [VALUE_W-1:0] left_data,
    input  wire logic [VALUE_W-1:0] right_data,
    input  wire logic               match_in,
    output logic      [VALUE_W-1:0] data,
    output logic                    match_out
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               eq_reg;
    logic               in_list;

    // A cell takes part only while it lies inside the list.
    assign in_list   = MY_IDX < len;
    assign match_out = match_in | (eq_reg & in_list);
    assign data      = data_reg;

    // Shift toward the tail on insert, toward the head on delete.
    always_comb begin
        data_next = data_reg;
        priority if (cmd.ins) begin
            if (MY_IDX > at_idx) begin
                data_next = left_data;
            end else if (MY_IDX == at_idx) begin
                data_next = value;
            end
        end else if (cmd.del_at) begin
            if (MY_IDX >= at_idx) begin
                data_next = right_data;
            end
        end else if (cmd.del_match && match_out) begin
            data_next = right_data;
        end else begin
            data_next = data_reg;
        end
    end

    // Entry storage and the registered compare.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (cmd.cmp) begin
            eq_reg <= (data_reg == value);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bole_ctrl.sv -----
`default_nettype none

module bole_ctrl
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LW       = 5,
    parameter int CW       = 5
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [ACTION_W-1:0] s_action,
    input  wire logic [VALUE_W-1:0]  s_value,
    input  wire logic [POS_W-1:0]    s_position,
    input  wire logic                chain_found,
    output cell_cmd_t                cmd,
    output logic      [CW-1:0]       at_idx,
    output logic      [CW-1:0]       len,
    output logic      [VALUE_W-1:0]  value,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [STATUS_W-1:0] m_status,
    output logic                     m_found,
    output logic      [LEN_W-1:0]    m_length
);

    state_t             state_reg, state_next;
    action_t            act_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [LW-1:0]      len_reg, len_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic               out_found_reg;
    logic [LEN_W-1:0]   out_len_reg;

    logic               accept;
    logic               exec_go;
    logic               full;
    logic               empty;
    logic [CW-1:0]      pos_ext;
    logic [CW-1:0]      len_ext;
    logic [CW-1:0]      len_next_ext;
    status_t            status_c;
    logic               found_c;
    logic               ins_c;
    logic               del_at_c;
    logic               del_match_c;
    logic [CW-1:0]      at_c;

    assign accept  = s_tvalid && s_tready;
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign full    = len_reg == LW'(CAPACITY);
    assign empty   = len_reg == '0;
    assign pos_ext = CW'(pos_reg);
    assign len_ext = CW'(len_reg);
    assign len     = len_ext;

    // Decide the outcome of the held item from the length and the match chain.
    always_comb begin
        status_c    = STAT_OK;
        found_c     = 1'b0;
        ins_c       = 1'b0;
        del_at_c    = 1'b0;
        del_match_c = 1'b0;
        at_c        = '0;
        unique case (act_reg)
            ACT_INS_HEAD: begin
                if (full) begin
                    status_c = STAT_FULL;
                end else begin
                    ins_c = 1'b1;
                end
            end
            ACT_INS_TAIL: begin
                at_c = len_ext;
                if (full) begin
                    status_c = STAT_FULL;
                end else begin
                    ins_c = 1'b1;
                end
            end
            ACT_INS_POS: begin
                at_c = pos_ext;
                if (pos_ext > len_ext) begin
                    status_c = STAT_BOUNDS;
                end else if (full) begin
                    status_c = STAT_FULL;
                end else begin
                    ins_c = 1'b1;
                end
            end
            ACT_DEL_VALUE: begin
                if (empty) begin
                    status_c = STAT_EMPTY;
                end else if (!chain_found) begin
                    status_c = STAT_NOTFOUND;
                end else begin
                    del_match_c = 1'b1;
                end
            end
            ACT_DEL_POS: begin
                at_c = pos_ext;
                if (empty) begin
                    status_c = STAT_EMPTY;
                end else if (pos_ext >= len_ext) begin
                    status_c = STAT_BOUNDS;
                end else begin
                    del_at_c = 1'b1;
                end
            end
            ACT_SEARCH: begin
                found_c = chain_found;
            end
            default: begin
                status_c = STAT_OK;
            end
        endcase
    end

    // New length after the action.
    always_comb begin
        len_next = len_reg;
        if (exec_go && ins_c) begin
            len_next = len_reg + LW'(1);
        end else if (exec_go && (del_at_c || del_match_c)) begin
            len_next = len_reg - LW'(1);
        end
    end

    assign len_next_ext = CW'(len_next);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake and cell commands.
    always_comb begin
        s_tready      = 1'b0;
        value         = value_reg;
        cmd.cmp       = 1'b0;
        cmd.ins       = 1'b0;
        cmd.del_at    = 1'b0;
        cmd.del_match = 1'b0;
        at_idx        = at_c;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                value    = s_value;
                cmd.cmp  = s_tvalid;
            end
            ST_EXEC: begin
                cmd.ins       = exec_go && ins_c;
                cmd.del_at    = exec_go && del_at_c;
                cmd.del_match = exec_go && del_match_c;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (exec_go) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Held item and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg   <= action_t'(s_action);
            value_reg <= s_value;
            pos_reg   <= s_position;
        end
        if (exec_go) begin
            out_status_reg <= status_c;
            out_found_reg  <= found_c;
            out_len_reg    <= len_next_ext[LEN_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_found  = out_found_reg;
    assign m_length = out_len_reg;

endmodule

`default_nettype wire

// ----- rtl/bounded_ordered_list_engine_core.sv -----
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one entry per cell. An item carries the action in s_tuser and the value and
// position in s_tdata; each item gives one result with a status, a found flag
// and the list length after the action. In the cycle an item is accepted,
// each cell registers the compare of its entry with the value; in the
// execute state the first-match flag ripples down the row of cells while
// the cells from the index or the match onward shift by one place at once.
// The result sits in an output register, so the next item is taken while a
// result waits, once the last has executed. Reset empties the list.

module bounded_ordered_list_engine_core
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // value [31:0], position [36:32], zero fill
    input  wire logic [2:0]  s_tuser,  // action [2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata   // status [2:0], found [3], length [8:4], zero fill
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    cell_cmd_t          cmd;
    logic [CW-1:0]      at_idx;
    logic [CW-1:0]      len;
    logic [VALUE_W-1:0] bcast_value;
    logic [VALUE_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY:0]  match_chain;
    logic [STATUS_W-1:0] m_status;
    logic               m_found;
    logic [LEN_W-1:0]   m_length;

    assign match_chain[0] = 1'b0;

    bole_ctrl #(
        .CAPACITY (CAPACITY),
        .LW       (LW),
        .CW       (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_action    (s_tuser),
        .s_value     (s_tdata[VALUE_W-1:0]),
        .s_position  (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .chain_found (match_chain[CAPACITY]),
        .cmd         (cmd),
        .at_idx      (at_idx),
        .len         (len),
        .value       (bcast_value),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (m_status),
        .m_found     (m_found),
        .m_length    (m_length)
    );

    // Row of cells; the ends take the broadcast value and their own entry.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] left_d;
        logic [VALUE_W-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = bcast_value;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        bole_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .at_idx     (at_idx),
            .len        (len),
            .value      (bcast_value),
            .left_data  (left_d),
            .right_data (right_d),
            .match_in   (match_chain[i]),
            .data       (cell_data[i]),
            .match_out  (match_chain[i+1])
        );
    end

    assign m_tdata = {7'd0, m_length, m_found, m_status};

endmodule

`default_nettype wire

// ----- sim/bounded_ordered_list_engine_core_test.sv -----
module bounded_ordered_list_engine_core_test;
    import bole_pkg::*;

    // Action codes that the block does not define; they must leave the list alone.
    localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 950;
    localparam int DIR_ROWS     = 22;

    // One reply of the block: status, found flag and length, as checked on m_tdata.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [LEN_W-1:0]    length;
    } list_reply_t;

    // One row of the directed table; a typed reply is used where known is set.
    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    pos;
        bit                  known;
        list_reply_t         reply;
    } directed_row_t;

    typedef enum int {
        TRAFFIC_FILL,
        TRAFFIC_DRAIN,
        TRAFFIC_BALANCED
    } traffic_mode_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // value [31:0], position [36:32], zero fill
    logic [2:0]  s_tuser  = '0;  // action [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // status [2:0], found [3], length [8:4], zero fill

    // Shadow copy of the list that the predictor keeps.
    logic [VALUE_W-1:0] shadow_cells [CAPACITY_DEF];
    int unsigned        shadow_count = 0;

    list_reply_t expected_replies [$];
    list_reply_t oldest_reply;
    bit          quiet_phase = 1'b0;

    int mismatch_count  = 0;
    int replies_checked = 0;
    int items_sent      = 0;
    int full_hits       = 0;
    int empty_hits      = 0;
    int bounds_hits     = 0;
    int found_hits      = 0;

    logic [VALUE_W-1:0] corner_values [5] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF
    };

    // Empty-list errors first, then the value extremes, bounds, unused codes
    // and deletes by value and by position.
    directed_row_t directed_rows [DIR_ROWS] = '{
        '{ACT_DEL_VALUE, 32'h0000_0000, 5'd0,  1'b1, '{STAT_EMPTY,    1'b0, 5'd0}},
        '{ACT_DEL_POS,   32'h0000_0000, 5'd0,  1'b1, '{STAT_EMPTY,    1'b0, 5'd0}},
        '{ACT_DEL_POS,   32'h0000_0000, 5'd31, 1'b1, '{STAT_EMPTY,    1'b0, 5'd0}},
        '{ACT_SEARCH,    32'h0000_0000, 5'd0,  1'b1, '{STAT_OK,       1'b0, 5'd0}},
        '{ACT_INS_POS,   32'h0000_0001, 5'd1,  1'b1, '{STAT_BOUNDS,   1'b0, 5'd0}},
        '{ACT_INS_POS,   32'h7FFF_FFFF, 5'd0,  1'b1, '{STAT_OK,       1'b0, 5'd1}},
        '{ACT_INS_HEAD,  32'h8000_0000, 5'd0,  1'b1, '{STAT_OK,       1'b0, 5'd2}},
        '{ACT_INS_TAIL,  32'hFFFF_FFFF, 5'd0,  1'b1, '{STAT_OK,       1'b0, 5'd3}},
        '{ACT_INS_POS,   32'h0000_0000, 5'd3,  1'b0, '0},
        '{ACT_INS_POS,   32'h0000_0005, 5'd31, 1'b1, '{STAT_BOUNDS,   1'b0, 5'd4}},
        '{ACT_SEARCH,    32'hFFFF_FFFF, 5'd0,  1'b0, '0},
        '{ACT_SEARCH,    32'h7FFF_FFFE, 5'd0,  1'b0, '0},
        '{ACT_UNUSED_6,  32'hFFFF_FFFF, 5'd31, 1'b1, '{STAT_OK,       1'b0, 5'd4}},
        '{ACT_UNUSED_7,  32'h0000_0000, 5'd0,  1'b1, '{STAT_OK,       1'b0, 5'd4}},
        '{ACT_DEL_POS,   32'h0000_0000, 5'd4,  1'b1, '{STAT_BOUNDS,   1'b0, 5'd4}},
        '{ACT_DEL_VALUE, 32'h1234_5678, 5'd0,  1'b1, '{STAT_NOTFOUND, 1'b0, 5'd4}},
        '{ACT_DEL_VALUE, 32'hFFFF_FFFF, 5'd0,  1'b0, '0},
        '{ACT_DEL_POS,   32'h0000_0000, 5'd0,  1'b0, '0},
        '{ACT_DEL_POS,   32'h0000_0000, 5'd1,  1'b0, '0},
        '{ACT_INS_TAIL,  32'h7FFF_FFFF, 5'd0,  1'b0, '0},
        '{ACT_DEL_VALUE, 32'h7FFF_FFFF, 5'd0,  1'b0, '0},
        '{ACT_SEARCH,    32'h7FFF_FFFF, 5'd0,  1'b0, '0}
    };

    bounded_ordered_list_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous limit on the whole run.
    initial begin
        #5_000_000;
        $display("Timed out with %0d replies outstanding.", expected_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Shift the cells at and above the slot up by one and load the value.
    function automatic void open_slot(int unsigned at, logic [VALUE_W-1:0] value);
        for (int unsigned i = shadow_count; i > at; i--) begin
            shadow_cells[i] = shadow_cells[i-1];
        end
        shadow_cells[at] = value;
        shadow_count++;
    endfunction

    // Shift the cells above the slot down by one.
    function automatic void close_slot(int unsigned at);
        for (int unsigned i = at; i + 1 < shadow_count; i++) begin
            shadow_cells[i] = shadow_cells[i+1];
        end
        shadow_count--;
    endfunction

    // Index of the first cell equal to the value, or -1.
    function automatic int find_value(logic [VALUE_W-1:0] value);
        for (int unsigned i = 0; i < shadow_count; i++) begin
            if (shadow_cells[i] == value) return i;
        end
        return -1;
    endfunction

    // Apply one action to the shadow list and return the reply it gives.
    function automatic list_reply_t apply_list_action(logic [ACTION_W-1:0] act,
                                                      logic [VALUE_W-1:0] value,
                                                      logic [POS_W-1:0] pos);
        list_reply_t reply;
        int          where;
        reply.status = STAT_OK;
        reply.found  = 1'b0;
        case (act)
            ACT_INS_HEAD: begin
                if (shadow_count >= CAPACITY_DEF) reply.status = STAT_FULL;
                else open_slot(0, value);
            end
            ACT_INS_TAIL: begin
                if (shadow_count >= CAPACITY_DEF) reply.status = STAT_FULL;
                else open_slot(shadow_count, value);
            end
            ACT_INS_POS: begin
                // The position is judged before fullness.
                if (pos > shadow_count) reply.status = STAT_BOUNDS;
                else if (shadow_count >= CAPACITY_DEF) reply.status = STAT_FULL;
                else open_slot(pos, value);
            end
            ACT_DEL_VALUE: begin
                where = find_value(value);
                if (shadow_count == 0) reply.status = STAT_EMPTY;
                else if (where < 0) reply.status = STAT_NOTFOUND;
                else close_slot(where);
            end
            ACT_DEL_POS: begin
                if (shadow_count == 0) reply.status = STAT_EMPTY;
                else if (pos >= shadow_count) reply.status = STAT_BOUNDS;
                else close_slot(pos);
            end
            ACT_SEARCH: begin
                reply.found = (find_value(value) >= 0);
            end
            default: begin
            end
        endcase
        reply.length = shadow_count[LEN_W-1:0];
        return reply;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Choose an action, leaning toward inserts or deletes by traffic mode.
    function automatic logic [ACTION_W-1:0] pick_action(traffic_mode_t mode);
        int r;
        int insert_share;
        if ($urandom_range(0, 99) < 4) begin
            return ($urandom_range(0, 1) != 0) ? ACT_UNUSED_6 : ACT_UNUSED_7;
        end
        case (mode)
            TRAFFIC_FILL:  insert_share = 75;
            TRAFFIC_DRAIN: insert_share = 20;
            default:       insert_share = 45;
        endcase
        r = $urandom_range(0, 99);
        if (r < insert_share) begin
            case ($urandom_range(0, 2))
                0:       return ACT_INS_HEAD;
                1:       return ACT_INS_TAIL;
                default: return ACT_INS_POS;
            endcase
        end
        if (r < insert_share + 12) return ACT_SEARCH;
        return ($urandom_range(0, 1) != 0) ? ACT_DEL_VALUE : ACT_DEL_POS;
    endfunction

    // Values: often one already in the list so deletes and searches hit.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && shadow_count > 0) return shadow_cells[$urandom_range(0, shadow_count - 1)];
        if (r < 70) return corner_values[$urandom_range(0, 4)];
        return $urandom();
    endfunction

    // Positions: mostly near the valid range, sometimes anywhere in the field.
    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, shadow_count + 1));
        return POS_W'($urandom_range(0, 31));
    endfunction

    // Print one mismatch and count it.
    task automatic report_mismatch(string what, int got, int want);
        $display("Mismatch on reply %0d: %s is %0d, expected %0d.",
                 replies_checked, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item and hold it until the block takes it, then record the reply.
    task automatic send_item(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value,
                             logic [POS_W-1:0] pos, bit known, list_reply_t typed_reply);
        list_reply_t predicted;
        int          gap;
        gap = random_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, pos, value};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_list_action(act, value, pos);
        expected_replies.push_back(known ? typed_reply : predicted);
        items_sent++;
        case (predicted.status)
            STAT_FULL:   full_hits++;
            STAT_EMPTY:  empty_hits++;
            STAT_BOUNDS: bounds_hits++;
            default: begin
            end
        endcase
        if (predicted.found) found_hits++;
    endtask

    // Result side: random back-pressure, with quiet stretches of none.
    initial begin
        repeat (8) @(posedge aclk);
        forever begin
            int stall;
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = random_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Compare every accepted reply with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected reply, m_tdata", m_tdata, 0);
            end else begin
                oldest_reply = expected_replies.pop_front();
                if (m_tdata[2:0] !== oldest_reply.status)
                    report_mismatch("status", m_tdata[2:0], oldest_reply.status);
                if (m_tdata[3] !== oldest_reply.found)
                    report_mismatch("found", m_tdata[3], oldest_reply.found);
                if (m_tdata[8:4] !== oldest_reply.length)
                    report_mismatch("length", m_tdata[8:4], oldest_reply.length);
            end
            replies_checked++;
        end
    end

    // Reset, directed table, random traffic in phases, then drain.
    initial begin
        traffic_mode_t mode;
        int            phase_len;
        int            random_sent;
        random_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].act, directed_rows[i].value, directed_rows[i].pos,
                      directed_rows[i].known, directed_rows[i].reply);
        end

        while (random_sent < RANDOM_ITEMS) begin
            mode        = traffic_mode_t'($urandom_range(0, 2));
            quiet_phase = ($urandom_range(0, 4) == 0);
            phase_len   = $urandom_range(20, 80);
            for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
                send_item(pick_action(mode), pick_value(), pick_position(), 1'b0, '0);
                random_sent++;
            end
        end
        quiet_phase = 1'b0;
        @(posedge aclk);
        s_tvalid <= 1'b0;

        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d items (%0d from the directed table), checked %0d replies.",
                 items_sent, DIR_ROWS, replies_checked);
        $display("Full-list inserts %0d, empty-list deletes %0d, out of bounds %0d, hits %0d.",
                 full_hits, empty_hits, bounds_hits, found_hits);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
